@@ rtl/pms_pkg.sv @@
// Shared types and constants for the power mode sequencer.
// Used by pms_step and power_mode_sequencer; depends on nothing else.
package pms_pkg;

  typedef enum logic [1:0] {
    MODE_BOOT      = 2'd0,
    MODE_CHARGING  = 2'd1,
    MODE_OPERATION = 2'd2,
    MODE_SHUTDOWN  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PHASE_UNSAMPLED = 2'd0,
    PHASE_QUALIFY   = 2'd1,
    PHASE_DONE      = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_HOLD     = 2'd1,
    REG_UNPLUG   = 2'd2,
    REG_QUALIFY  = 2'd3
  } reg_idx_e;

  localparam int ShortW   = 10;
  localparam int LongW    = 16;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;

  localparam logic [ShortW-1:0] DebounceReset = 10'd50;
  localparam logic [LongW-1:0]  HoldReset     = 16'd2000;
  localparam logic [LongW-1:0]  UnplugReset   = 16'd500;
  localparam logic [ShortW-1:0] QualifyReset  = 10'd120;

  typedef struct packed {
    logic [ShortW-1:0] debounce_ticks;
    logic [LongW-1:0]  hold_ticks;
    logic [LongW-1:0]  unplug_ticks;
    logic [ShortW-1:0] boot_qualify_ticks;
  } pms_cfg_t;

  // Sequencer state apart from the two long timers, whose width is a parameter.
  typedef struct packed {
    mode_e             mode;
    phase_e            phase;
    logic              boot_button_held;
    logic [ShortW-1:0] boot_counter;
    logic              awaiting_long_press;
    logic              button_prev;
    logic [ShortW-1:0] debounce_counter;
    logic              debounce_running;
    logic              hold_running;
    logic              saw_plugged;
    logic              unplug_timing;
  } pms_state_t;

  typedef struct packed {
    logic  mode_changed;
    logic  display_slow;
    logic  system_off;
    mode_e power_mode;
  } pms_result_t;

endpackage

@@ rtl/power_mode_sequencer.sv @@
// Power mode sequencer: boot check, charging, operation and shutdown modes.
// Holds the state, configuration and output registers; depends on pms_pkg
// and pms_step.
//
// Usage:
//   Each request on the slave stream is one millisecond tick carrying the
//   button level (bit 0, low = pressed) and charger level (bit 1, low =
//   plugged). Every tick yields exactly one result on the master stream.
//   The result is registered and appears the cycle after the tick is taken.
//   One tick per cycle is taken while results are accepted; the state update
//   for a tick is a single pass through pms_step into the state and output
//   registers. When the receiver stalls, the output register holds its
//   result and the slave side stops taking ticks until that result is taken;
//   a new tick is taken in the same cycle the held result leaves.
//   The configuration channel is always ready; it writes one of the four
//   timer limits by index and should only be used while no tick is pending.
//   Reset puts the block into boot check with the default limits (50, 2000,
//   500, 120 ticks) and an empty output register. After shutdown the block
//   ignores its inputs and keeps reporting shutdown with system_off set.
module power_mode_sequencer #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pms_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [pms_pkg::CfgDataW-1:0]  cfg_data_i,
  // Tick stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [0] button_level, [1] charger_level
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata   // [1:0] power_mode, [2] system_off,
                                                       // [3] display_slow, [4] mode_changed
);
  import pms_pkg::*;

  pms_cfg_t           cfg_q;
  pms_state_t         state_q, state_d;
  logic [TIMER_WIDTH-1:0] hold_cnt_q, hold_cnt_d;
  logic [TIMER_WIDTH-1:0] unplug_cnt_q, unplug_cnt_d;
  pms_result_t        result_d;
  logic [7:0]         tdata_q;
  logic               tvalid_q;
  logic               in_fire;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~tvalid_q | m_axis_tready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= DebounceReset;
      cfg_q.hold_ticks         <= HoldReset;
      cfg_q.unplug_ticks       <= UnplugReset;
      cfg_q.boot_qualify_ticks <= QualifyReset;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_DEBOUNCE: cfg_q.debounce_ticks     <= cfg_data_i[ShortW-1:0];
        REG_HOLD:     cfg_q.hold_ticks         <= cfg_data_i[LongW-1:0];
        REG_UNPLUG:   cfg_q.unplug_ticks       <= cfg_data_i[LongW-1:0];
        REG_QUALIFY:  cfg_q.boot_qualify_ticks <= cfg_data_i[ShortW-1:0];
        default:      cfg_q                    <= cfg_q;
      endcase
    end
  end

  pms_step #(
    .TimerW (TIMER_WIDTH)
  ) u_step (
    .cfg_i           (cfg_q),
    .state_i         (state_q),
    .hold_cnt_i      (hold_cnt_q),
    .unplug_cnt_i    (unplug_cnt_q),
    .button_level_i  (s_axis_tdata[0]),
    .charger_level_i (s_axis_tdata[1]),
    .state_o         (state_d),
    .hold_cnt_o      (hold_cnt_d),
    .unplug_cnt_o    (unplug_cnt_d),
    .result_o        (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode                <= MODE_BOOT;
      state_q.phase               <= PHASE_UNSAMPLED;
      state_q.boot_button_held    <= 1'b0;
      state_q.boot_counter        <= '0;
      state_q.awaiting_long_press <= 1'b0;
      state_q.button_prev         <= 1'b1;
      state_q.debounce_counter    <= '0;
      state_q.debounce_running    <= 1'b0;
      state_q.hold_running        <= 1'b0;
      state_q.saw_plugged         <= 1'b0;
      state_q.unplug_timing       <= 1'b0;
      hold_cnt_q                  <= '0;
      unplug_cnt_q                <= '0;
    end else if (in_fire) begin
      state_q      <= state_d;
      hold_cnt_q   <= hold_cnt_d;
      unplug_cnt_q <= unplug_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (s_axis_tready) begin
      tvalid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tdata_q <= {3'b000, result_d.mode_changed, result_d.display_slow,
                  result_d.system_off, result_d.power_mode};
    end
  end

endmodule

@@ rtl/pms_step.sv @@
// Next-state logic of the power mode sequencer for one millisecond tick.
// Purely combinational; depends on pms_pkg.
module pms_step #(
  parameter int TimerW = 16
) (
  input  pms_pkg::pms_cfg_t   cfg_i,
  input  pms_pkg::pms_state_t state_i,
  input  logic [TimerW-1:0]   hold_cnt_i,
  input  logic [TimerW-1:0]   unplug_cnt_i,
  input  logic                button_level_i,
  input  logic                charger_level_i,
  output pms_pkg::pms_state_t state_o,
  output logic [TimerW-1:0]   hold_cnt_o,
  output logic [TimerW-1:0]   unplug_cnt_o,
  output pms_pkg::pms_result_t result_o
);
  import pms_pkg::*;

  localparam int CmpW = (TimerW > LongW) ? TimerW : LongW;

  pms_state_t        st;
  logic [TimerW-1:0] hold_cnt;
  logic [TimerW-1:0] unplug_cnt;
  logic              released;
  logic              plugged;
  logic              long_press;
  logic              release_ev;

  always_comb begin
    st         = state_i;
    hold_cnt   = hold_cnt_i;
    unplug_cnt = unplug_cnt_i;
    released   = button_level_i;
    plugged    = ~charger_level_i;
    long_press = 1'b0;
    release_ev = 1'b0;

    if (st.mode != MODE_SHUTDOWN) begin
      // Hold timer runs first so a long press sees this tick's level.
      if (st.hold_running) begin
        if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
        if (CmpW'(hold_cnt) >= CmpW'(cfg_i.hold_ticks)) begin
          st.hold_running = 1'b0;
          if (!released) long_press = 1'b1;
        end
      end

      if (released != st.button_prev) begin
        st.debounce_running = 1'b1;
        st.debounce_counter = '0;
        st.button_prev      = released;
      end else if (st.debounce_running) begin
        if (st.debounce_counter != '1) st.debounce_counter = st.debounce_counter + 1'b1;
        if (st.debounce_counter >= cfg_i.debounce_ticks) begin
          st.debounce_running = 1'b0;
          if (!released) begin
            st.hold_running = 1'b1;
            hold_cnt        = '0;
          end else begin
            st.hold_running = 1'b0;
            if (st.awaiting_long_press) release_ev = 1'b1;
          end
        end
      end

      if (release_ev && st.awaiting_long_press) begin
        st.awaiting_long_press = 1'b0;
        if (plugged) begin
          st.mode          = MODE_CHARGING;
          st.unplug_timing = 1'b0;
          unplug_cnt       = '0;
          st.saw_plugged   = 1'b1;
        end else begin
          st.mode = MODE_SHUTDOWN;
        end
      end else if (long_press) begin
        if (st.awaiting_long_press) begin
          st.awaiting_long_press = 1'b0;
          st.mode                = MODE_OPERATION;
        end else if (st.mode == MODE_CHARGING) begin
          st.mode = MODE_OPERATION;
        end else if (st.mode == MODE_OPERATION) begin
          if (plugged) begin
            st.mode          = MODE_CHARGING;
            st.unplug_timing = 1'b0;
            unplug_cnt       = '0;
            st.saw_plugged   = 1'b1;
          end else begin
            st.mode = MODE_SHUTDOWN;
          end
        end
      end

      if (st.mode == MODE_BOOT && st.phase != PHASE_DONE) begin
        if (st.phase == PHASE_UNSAMPLED) begin
          st.boot_button_held = ~released;
          st.boot_counter     = '0;
          st.phase            = PHASE_QUALIFY;
        end
        if (plugged) begin
          if (st.boot_counter != '1) st.boot_counter = st.boot_counter + 1'b1;
          if (st.boot_counter >= cfg_i.boot_qualify_ticks) begin
            st.phase               = PHASE_DONE;
            st.awaiting_long_press = 1'b0;
            st.mode                = MODE_CHARGING;
            st.unplug_timing       = 1'b0;
            unplug_cnt             = '0;
            st.saw_plugged         = 1'b1;
          end
        end else begin
          // No charger at boot: either wait for a long press or run.
          st.phase = PHASE_DONE;
          if (st.boot_button_held) begin
            st.awaiting_long_press = 1'b1;
            st.hold_running        = 1'b0;
            hold_cnt               = '0;
            st.debounce_running    = 1'b1;
            st.debounce_counter    = '0;
          end else begin
            st.mode = MODE_OPERATION;
          end
        end
      end

      if (st.mode == MODE_CHARGING) begin
        if (plugged) begin
          st.saw_plugged   = 1'b1;
          st.unplug_timing = 1'b0;
          unplug_cnt       = '0;
        end else if (st.saw_plugged) begin
          if (!st.unplug_timing) begin
            st.unplug_timing = 1'b1;
            unplug_cnt       = '0;
          end else begin
            if (unplug_cnt != '1) unplug_cnt = unplug_cnt + 1'b1;
            if (CmpW'(unplug_cnt) >= CmpW'(cfg_i.unplug_ticks)) st.mode = MODE_SHUTDOWN;
          end
        end
      end
    end
  end

  assign state_o      = st;
  assign hold_cnt_o   = hold_cnt;
  assign unplug_cnt_o = unplug_cnt;

  assign result_o.power_mode   = st.mode;
  assign result_o.system_off   = (st.mode == MODE_SHUTDOWN);
  assign result_o.display_slow = (st.mode == MODE_CHARGING);
  assign result_o.mode_changed = (st.mode != state_i.mode);

endmodule
